// File: src/fle_pkg.sv
package fle_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 11;
  localparam int LOG_W    = 16;
  localparam int ENERGY_W = 41;
  // a squared 16-bit sample is at most 2^30
  localparam int SQ_W     = 2 * SAMPLE_W - 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_LEN      = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_LENGTH_RST = 11'd400;
  localparam logic [CFG_W-1:0] HOP_LEN_RST      = 11'd160;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  // log10(2) in Q16
  localparam logic [14:0] LOG10_2_Q16 = 15'd19728;

  localparam int OUT_FIFO_DEPTH = 16;

  // log2(1 + i/32) in Q16
  localparam logic [16:0] LOG2_TAB [33] = '{
    17'd0,     17'd2909,  17'd5732,  17'd8473,  17'd11136, 17'd13727, 17'd16248, 17'd18704,
    17'd21098, 17'd23433, 17'd25711, 17'd27936, 17'd30109, 17'd32234, 17'd34312, 17'd36346,
    17'd38336, 17'd40286, 17'd42196, 17'd44068, 17'd45904, 17'd47705, 17'd49472, 17'd51207,
    17'd52911, 17'd54584, 17'd56229, 17'd57845, 17'd59434, 17'd60997, 17'd62534, 17'd64047,
    17'd65536
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first;
  } in_item_t;

  typedef struct packed {
    logic [LOG_W-1:0]    log_energy;
    logic [ENERGY_W-1:0] frame_energy;
  } out_item_t;

endpackage

// File: src/fle_log.sv
module fle_log #(
  parameter int SUM_W         = 41,
  parameter int LOG_FRAC_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  energy,
  output logic              out_valid,
  output fle_pkg::out_item_t out_data
);
  import fle_pkg::*;

  localparam int NG   = (SUM_W + 7) / 8;
  localparam int KW   = $clog2(SUM_W);
  localparam int SH   = 32 - LOG_FRAC_BITS;
  localparam int L2_W = KW + 17;
  localparam int M_W  = L2_W + 15;
  localparam int EW   = (SUM_W > ENERGY_W) ? SUM_W : ENERGY_W;

  logic [6:0] v_r;

  // stage 1: per-byte leading one
  logic [NG*8-1:0]  ep;
  logic [NG-1:0]    nz;
  logic [2:0]       pos [NG];
  logic [NG-1:0]    nz1_r;
  logic [2:0]       pos1_r [NG];
  logic [SUM_W-1:0] e1_r;

  // stage 2: pick the top byte
  logic [KW-1:0]    k_c;
  logic             zero_c;
  logic [KW-1:0]    k2_r;
  logic             zero2_r;
  logic [SUM_W-1:0] e2_r;

  // stage 3: normalise
  logic [SUM_W+15:0] norm;
  logic [15:0]       f3_r;
  logic [KW-1:0]     k3_r;
  logic              zero3_r;
  logic [SUM_W-1:0]  e3_r;

  // stage 4: table and interpolation product
  logic [4:0]       idx;
  logic [5:0]       idx_nxt;
  logic [16:0]      diff_full;
  logic [16:0]      base4_r;
  logic [22:0]      prod4_r;
  logic [KW-1:0]    k4_r;
  logic             zero4_r;
  logic [SUM_W-1:0] e4_r;

  // stage 5: log2 in Q16
  logic [22:0]      prod_rnd;
  logic [16:0]      frac;
  logic [L2_W-1:0]  l2_5_r;
  logic             zero5_r;
  logic [SUM_W-1:0] e5_r;

  // stage 6: scale by log10(2)
  logic [M_W-1:0]   m6_r;
  logic             zero6_r;
  logic [SUM_W-1:0] e6_r;

  // stage 7: round, saturate
  logic [M_W:0]     rnd;
  logic [M_W:0]     q;
  logic [EW-1:0]    e_ext;
  out_item_t        res_c;
  out_item_t        out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_comb begin
    ep = (NG*8)'(energy);
    for (int g = 0; g < NG; g++) begin
      nz[g]  = |ep[g*8 +: 8];
      pos[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (ep[g*8+b]) begin
          pos[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    nz1_r  <= nz;
    pos1_r <= pos;
    e1_r   <= energy;
  end

  always_comb begin
    k_c    = '0;
    zero_c = 1'b1;
    for (int g = 0; g < NG; g++) begin
      if (nz1_r[g]) begin
        k_c    = KW'(g * 8) + KW'(pos1_r[g]);
        zero_c = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k2_r    <= k_c;
    zero2_r <= zero_c;
    e2_r    <= e1_r;
  end

  // the 16 bits below the leading one
  assign norm = {e2_r, 16'b0} >> k2_r;

  always_ff @(posedge clk) begin
    f3_r    <= norm[15:0];
    k3_r    <= k2_r;
    zero3_r <= zero2_r;
    e3_r    <= e2_r;
  end

  assign idx       = f3_r[15:11];
  assign idx_nxt   = {1'b0, idx} + 6'd1;
  assign diff_full = LOG2_TAB[idx_nxt] - LOG2_TAB[idx];

  always_ff @(posedge clk) begin
    base4_r <= LOG2_TAB[idx];
    prod4_r <= 23'(diff_full[11:0]) * 23'(f3_r[10:0]);
    k4_r    <= k3_r;
    zero4_r <= zero3_r;
    e4_r    <= e3_r;
  end

  assign prod_rnd = prod4_r + 23'd1024;
  assign frac     = base4_r + 17'(prod_rnd >> 11);

  always_ff @(posedge clk) begin
    l2_5_r  <= (L2_W'(k4_r) << 16) + L2_W'(frac);
    zero5_r <= zero4_r;
    e5_r    <= e4_r;
  end

  always_ff @(posedge clk) begin
    m6_r    <= M_W'(l2_5_r) * M_W'(LOG10_2_Q16);
    zero6_r <= zero5_r;
    e6_r    <= e5_r;
  end

  always_comb begin
    rnd   = {1'b0, m6_r} + ((M_W+1)'(1) << (SH - 1));
    q     = rnd >> SH;
    e_ext = EW'(e6_r);
    if (zero6_r) begin
      res_c.log_energy = '0;
    end else if (q > (M_W+1)'(16'hFFFF)) begin
      res_c.log_energy = '1;
    end else begin
      res_c.log_energy = LOG_W'(q);
    end
    if (e_ext > EW'(ENERGY_MAX)) begin
      res_c.frame_energy = ENERGY_MAX;
    end else begin
      res_c.frame_energy = ENERGY_W'(e_ext);
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res_c;
  end

  assign out_valid = v_r[6];
  assign out_data  = out_r;

endmodule

// File: src/fle_fifo.sv
module fle_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  fle_pkg::out_item_t wr_data,
  input  logic               rd_en,
  output logic               rd_valid,
  output fle_pkg::out_item_t rd_data
);
  import fle_pkg::*;

  localparam int PW = $clog2(OUT_FIFO_DEPTH);
  localparam int CW = $clog2(OUT_FIFO_DEPTH + 1);

  out_item_t       mem [OUT_FIFO_DEPTH];
  out_item_t       head_r;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_rd;

  assign rd_valid = (count_r != '0);
  assign rd_data  = head_r;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(wr_en) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
    // head entry registered, taken straight from the write side when it lands there now
    if (wr_en && wr_ptr_r == rd_ptr_nxt) begin
      head_r <= wr_data;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

// File: src/frame_log_energy.sv
// short-time log energy of a 16-bit audio stream
//
// input channel (in_valid / in_stall / in_data): one signed sample per
// transaction, with a first flag that restarts the window at that sample.
// once frame_length samples have arrived one result is produced, then one
// every hop length samples; leftover samples at the end give nothing.
// result channel (out_valid / out_stall / out_data): frame energy and
// log10 of it in unsigned q4.12.
// config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// frame_length, 1 is the hop length; any write to either restarts the window.
// cfg_ready is always high; write only while the block is idle.
// throughput: one sample per cycle while in_stall is low, set by the
// single-port-per-side sample ring (one write and one read each cycle)
// and the running-sum adder. path to the output: ring read, squares, sum
// change, running sum, the log unit stages, then the result queue.
// a 16-entry result queue sits at the output: samples keep flowing while
// the receiver stalls, until 16 results are waiting or in flight.
// reset: frame_length 400, hop length 160, window empty, queue empty.
module frame_log_energy #(
  parameter int MAX_FRAME_LEN = 1024,
  parameter int LOG_FRAC_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fle_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fle_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fle_pkg::CFG_W-1:0]          cfg_data
);
  import fle_pkg::*;

  localparam int AW     = $clog2(MAX_FRAME_LEN);
  localparam int LEN_W  = $clog2(MAX_FRAME_LEN + 1);
  localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int SUM_W  = SQ_W + AW;
  localparam int CNT_W  = $clog2(OUT_FIFO_DEPTH + 1);

  // configuration
  logic [CFG_W-1:0] frame_length_r, hop_len_r;
  logic             cfg_wr;
  logic             cfg_restart;

  // window bookkeeping
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0] hop_r, hop_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;

  logic [CMP_W-1:0] fl_ext, fs_ext, len_ext;
  logic [LEN_W-1:0] len_eff, shift_eff;
  logic             in_acc;
  logic             restart;
  logic [LEN_W-1:0] fill_cur, hop_cur, hop_inc, wp_ext;
  logic [AW-1:0]    wp_cur;
  logic [AW-1:0]    old_addr;
  logic             sub_old;
  logic             emit;

  // sample ring
  logic [SAMPLE_W-1:0] ring [MAX_FRAME_LEN];
  logic [SAMPLE_W-1:0] ring_q;

  // squaring and running sum pipeline
  logic                v1_r, v2_r, v3_r;
  logic                emit1_r, emit2_r, emit3_r, emit4_r;
  logic                rst1_r, rst2_r, rst3_r;
  logic                sub1_r, sub2_r;
  logic [SAMPLE_W-1:0] s1_r;
  logic [SAMPLE_W:0]   mag_new, mag_old;
  logic [2*SAMPLE_W+1:0] sq_new_full, sq_old_full;
  logic [SQ_W-1:0]     sqn2_r, sqo2_r;
  logic [SQ_W:0]       delta_c, delta3_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;

  // output side
  logic      log_valid;
  out_item_t log_data;
  logic      out_take;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_wr &&
                       (cfg_index == REG_FRAME_LENGTH || cfg_index == REG_HOP_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= FRAME_LENGTH_RST;
      hop_len_r      <= HOP_LEN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_FRAME_LENGTH: frame_length_r <= cfg_data;
        REG_HOP_LEN:      hop_len_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective length and shift after clamping
  always_comb begin
    fl_ext = CMP_W'(frame_length_r);
    fs_ext = CMP_W'(hop_len_r);
    if (frame_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (fl_ext > CMP_W'(MAX_FRAME_LEN)) begin
      len_eff = LEN_W'(MAX_FRAME_LEN);
    end else begin
      len_eff = LEN_W'(frame_length_r);
    end
    len_ext = CMP_W'(len_eff);
    if (hop_len_r == '0) begin
      shift_eff = LEN_W'(1);
    end else if (fs_ext > len_ext) begin
      shift_eff = len_eff;
    end else begin
      shift_eff = LEN_W'(hop_len_r);
    end
  end

  // ---------------------------------------------------------------------
  // input side: hold off only when every result slot is spoken for
  // ---------------------------------------------------------------------
  assign in_stall = (cnt_r == CNT_W'(OUT_FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign restart  = in_data.first;

  always_comb begin
    fill_cur = restart ? '0 : fill_r;
    hop_cur  = restart ? '0 : hop_r;
    wp_cur   = restart ? '0 : wp_r;
    wp_ext   = LEN_W'(wp_cur);

    // slot of the sample leaving the window, wrapping at the ring depth
    if (wp_ext >= len_eff) begin
      old_addr = AW'(wp_ext - len_eff);
    end else begin
      old_addr = AW'(wp_ext + LEN_W'(MAX_FRAME_LEN) - len_eff);
    end
    sub_old = (fill_cur >= len_eff);

    wp_nxt  = (wp_cur == AW'(MAX_FRAME_LEN - 1)) ? '0 : wp_cur + AW'(1);
    hop_inc = hop_cur + LEN_W'(1);

    if (fill_cur < len_eff) begin
      fill_nxt = fill_cur + LEN_W'(1);
      emit     = (fill_nxt == len_eff);
      hop_nxt  = emit ? '0 : hop_cur;
    end else begin
      fill_nxt = fill_cur;
      emit     = (hop_inc >= shift_eff);
      hop_nxt  = emit ? '0 : hop_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      hop_r  <= '0;
      wp_r   <= '0;
    end else if (cfg_restart) begin
      fill_r <= '0;
      hop_r  <= '0;
      wp_r   <= '0;
    end else if (in_acc) begin
      fill_r <= fill_nxt;
      hop_r  <= hop_nxt;
      wp_r   <= wp_nxt;
    end
  end

  // ring: new sample written at the write slot, oldest one read out
  // (read-first, so a full-depth window still sees the outgoing sample)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring[wp_cur] <= in_data.sample;
      ring_q       <= ring[old_addr];
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: squares of the incoming and outgoing samples
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      emit1_r <= 1'b0;
      emit2_r <= 1'b0;
      emit3_r <= 1'b0;
      emit4_r <= 1'b0;
    end else begin
      v1_r    <= in_acc;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      emit1_r <= in_acc && emit;
      emit2_r <= emit1_r;
      emit3_r <= emit2_r;
      emit4_r <= v3_r && emit3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r   <= in_data.sample;
    sub1_r <= sub_old;
    rst1_r <= restart;
  end

  always_comb begin
    mag_new = s1_r[SAMPLE_W-1] ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, s1_r}
                               : {1'b0, s1_r};
    mag_old = ring_q[SAMPLE_W-1] ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, ring_q}
                                 : {1'b0, ring_q};
    sq_new_full = mag_new * mag_new;
    sq_old_full = mag_old * mag_old;
  end

  always_ff @(posedge clk) begin
    sqn2_r <= sq_new_full[SQ_W-1:0];
    sqo2_r <= sq_old_full[SQ_W-1:0];
    sub2_r <= sub1_r;
    rst2_r <= rst1_r;
  end

  // ---------------------------------------------------------------------
  // stage 2: signed change of the window sum
  // ---------------------------------------------------------------------
  assign delta_c = {1'b0, sqn2_r} - (sub2_r ? {1'b0, sqo2_r} : '0);

  always_ff @(posedge clk) begin
    delta3_r <= delta_c;
    rst3_r   <= rst2_r;
  end

  // ---------------------------------------------------------------------
  // stage 3: running sum of squares
  // ---------------------------------------------------------------------
  assign sum_nxt = (rst3_r ? '0 : sum_r) +
                   {{(SUM_W-SQ_W-1){delta3_r[SQ_W]}}, delta3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cfg_restart) begin
      sum_r <= '0;
    end else if (v3_r) begin
      sum_r <= sum_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // log10 unit, then the result queue
  // ---------------------------------------------------------------------
  fle_log #(
    .SUM_W         (SUM_W),
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (emit4_r),
    .energy    (sum_r),
    .out_valid (log_valid),
    .out_data  (log_data)
  );

  fle_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (log_valid),
    .wr_data  (log_data),
    .rd_en    (!out_stall),
    .rd_valid (out_valid),
    .rd_data  (out_data)
  );

  // results accepted but not yet delivered, queued or still in the pipe
  assign out_take = out_valid && !out_stall;
  assign cnt_nxt  = cnt_r + CNT_W'(in_acc && emit) - CNT_W'(out_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fle_pkg::*;

  localparam int RING_DEPTH    = 1024;
  // log10(2) in q16, and the shift that leaves 12 fraction bits
  localparam int LOG10_2_SCALE = 19728;
  localparam int LOG_SHIFT     = 20;
  // settle time, with margin over the block's pipeline
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 250;
  localparam int RANDOM_ITEMS  = 150;
  localparam int N_ROWS        = 30;

  // indexes with no register behind them, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;
  typedef enum int {STALL_NONE, STALL_MASK, STALL_COIN, STALL_RARE} stall_mode_e;

  // one line of the directed table: a register write or a sample, with an
  // optional hand-typed frame where the answer is obvious
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [15:0]           arg;
    logic                  first;
    logic                  typed;
    logic [LOG_W-1:0]      log_e;
    logic [ENERGY_W-1:0]   energy;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  // log2(1 + i/32) in q16
  int unsigned log2_q16 [0:32] = '{
    0, 2909, 5732, 8473, 11136, 13727, 16248, 18704,
    21098, 23433, 25711, 27936, 30109, 32234, 34312, 36346,
    38336, 40286, 42196, 44068, 45904, 47705, 49472, 51207,
    52911, 54584, 56229, 57845, 59434, 60997, 62534, 64047,
    65536
  };

  // directed table; frames of one sample have energy = sample squared,
  // and for a power-of-two energy 2^k the log is k * 1233
  row_t directed_rows [N_ROWS] = '{
    '{ROW_WRITE,  REG_FRAME_LENGTH, 16'd1,     1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_WRITE,  REG_HOP_LEN,      16'd1,     1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd0,     1'b0, 1'b1, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd1,     1'b0, 1'b1, 16'd0,     41'd1},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'hFFFF,  1'b0, 1'b1, 16'd0,     41'd1},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd2,     1'b0, 1'b1, 16'd2466,  41'd4},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'hFFFE,  1'b0, 1'b1, 16'd2466,  41'd4},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd256,   1'b0, 1'b1, 16'd19728, 41'd65536},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd16384, 1'b0, 1'b1, 16'd34524, 41'd268435456},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'h8000,  1'b0, 1'b1, 16'd36990, 41'd1073741824},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'h7FFF,  1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'h5555,  1'b1, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'hAAAA,  1'b0, 1'b0, 16'd0,     41'd0},
    // zero length and zero shift both behave as one
    '{ROW_WRITE,  REG_FRAME_LENGTH, 16'd0,     1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_WRITE,  REG_HOP_LEN,      16'd0,     1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'h8000,  1'b1, 1'b1, 16'd36990, 41'd1073741824},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd12345, 1'b0, 1'b0, 16'd0,     41'd0},
    // shift above length is cut back to the length
    '{ROW_WRITE,  REG_FRAME_LENGTH, 16'd3,     1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_WRITE,  REG_HOP_LEN,      16'd5,     1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd100,   1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'hFF9C,  1'b0, 1'b0, 16'd0,     41'd0},
    // writes to spare indexes must leave the half-filled window alone
    '{ROW_WRITE,  REG_SPARE_2,      16'd2047,  1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_WRITE,  REG_SPARE_3,      16'd1234,  1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd300,   1'b0, 1'b0, 16'd0,     41'd0},
    // first flag mid-stream restarts the window
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd1,     1'b1, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd2,     1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd3,     1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd4,     1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd5,     1'b0, 1'b0, 16'd0,     41'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 16'd6,     1'b0, 1'b0, 16'd0,     41'd0}
  };

  // shadow of the block: sample ring, running sum and counters
  logic [15:0]        ring [RING_DEPTH];
  logic [63:0]        win_sum;
  int                 fill_cnt;
  int                 hop_cnt;
  int                 wr_pos;
  logic [CFG_W-1:0]   len_reg;
  logic [CFG_W-1:0]   shift_reg;

  // frames predicted but not yet seen at the output, oldest first
  out_item_t          frames_due [$];
  out_item_t          due_frame;

  int                 n_err;
  int                 n_shown;
  bit                 hold_req;
  int                 burst_left;
  int                 rand_sent;

  frame_log_energy i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] square_of_sample(logic [15:0] raw);
    longint s;
    s = longint'($signed(raw));
    return 64'(s * s);
  endfunction

  // log10 in q4.12 via leading one, table lookup with linear interpolation
  function automatic logic [LOG_W-1:0] log10_q412(logic [63:0] e);
    int          k;
    int          ix;
    logic [15:0] f;
    int unsigned lo;
    int unsigned hi;
    int unsigned frac;
    logic [63:0] l2;
    logic [63:0] prod;
    if (e == 0) return '0;
    k = 0;
    while (k < 63 && (e >> (k + 1)) != 0) k++;
    if (k >= 16) f = 16'(e >> (k - 16));
    else f = 16'(e << (16 - k));
    ix   = int'(f[15:11]);
    lo   = log2_q16[ix];
    hi   = log2_q16[ix + 1];
    frac = lo + (((hi - lo) * 32'(f[10:0]) + 32'd1024) >> 11);
    l2   = (64'(k) << 16) + 64'(frac);
    prod = (l2 * 64'(LOG10_2_SCALE) + (64'd1 << (LOG_SHIFT - 1))) >> LOG_SHIFT;
    if (prod > 64'hFFFF) prod = 64'hFFFF;
    return prod[LOG_W-1:0];
  endfunction

  task automatic restart_window();
    win_sum  = '0;
    fill_cnt = 0;
    hop_cnt  = 0;
    wr_pos   = 0;
  endtask

  // advance the shadow by one sample, and say whether a frame closes here
  task automatic predict_frame(input in_item_t it, output bit emit, output out_item_t res);
    int len;
    int sh;
    int old;
    if (it.first) restart_window();
    len = (len_reg == 0) ? 1 : (len_reg > RING_DEPTH) ? RING_DEPTH : int'(len_reg);
    sh  = (shift_reg == 0) ? 1 : (shift_reg > len) ? len : int'(shift_reg);
    emit = 1'b0;
    // oldest sample drops out once the window is full
    if (fill_cnt >= len) begin
      old = (wr_pos + RING_DEPTH - len) % RING_DEPTH;
      win_sum -= square_of_sample(ring[old]);
    end
    ring[wr_pos] = it.sample;
    wr_pos = (wr_pos + 1) % RING_DEPTH;
    win_sum += square_of_sample(it.sample);
    if (fill_cnt < len) begin
      fill_cnt++;
      if (fill_cnt == len) begin
        emit = 1'b1;
        hop_cnt = 0;
      end
    end else begin
      hop_cnt++;
      if (hop_cnt >= sh) begin
        emit = 1'b1;
        hop_cnt = 0;
      end
    end
    res.frame_energy = (win_sum > ENERGY_MAX) ? ENERGY_MAX : win_sum[ENERGY_W-1:0];
    res.log_energy   = log10_q412(win_sum);
  endtask

  // offer one sample; entered and left at a falling edge. the sender works
  // in bursts with random gaps, and now and then a long burst with no gaps
  task automatic push_sample(input in_item_t it, input bit typed, input out_item_t typed_res);
    int        gap;
    bit        emit;
    out_item_t res;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_frame(it, emit, res);
    if (emit) frames_due.insert(frames_due.size(), typed ? typed_res : res);
    @(negedge clk);
  endtask

  // sender pause until every outstanding frame has come out
  task automatic drain_frames();
    in_valid <= 1'b0;
    do @(negedge clk); while (frames_due.size() != 0);
  endtask

  // quiet point for register writes: nothing outstanding, and enough
  // further cycles for a sample that closes no frame to clear the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    // a write to a real register also restarts the window
    if (idx == REG_FRAME_LENGTH) begin
      len_reg = val;
      restart_window();
    end else if (idx == REG_HOP_LEN) begin
      shift_reg = val;
      restart_window();
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample(int style);
    int r;
    r = $urandom_range(0, 99);
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 16) - 8);
      // mostly full scale, to push the window towards its largest energy
      2: begin
        if (r < 40) return 16'h8000;
        else if (r < 75) return 16'h7FFF;
        else if (r < 85) return 16'h0000;
        else return 16'($urandom);
      end
      // long runs of silence give zero-energy frames
      3: begin
        if (r < 90) return 16'h0000;
        else return 16'($urandom_range(0, 2) - 1);
      end
      default: begin
        if (r < 50) return 16'($urandom);
        else if (r < 70) return 16'($urandom_range(0, 16) - 8);
        else if (r < 80) return 16'h0000;
        else return r[0] ? 16'h8000 : 16'h7FFF;
      end
    endcase
  endfunction

  // one stretch of stimulus under one setting
  task automatic run_phase(input bit do_write, input logic [CFG_W-1:0] len_val,
                           input logic [CFG_W-1:0] shift_val, input int n_items,
                           input int style, input int first_odds, input bit hold);
    in_item_t  it;
    out_item_t none;
    int        pause_at;
    int        r;
    none = '0;
    settle();
    if (do_write) begin
      r = $urandom_range(0, 7);
      if (r != 0) write_reg(REG_FRAME_LENGTH, len_val);
      if (r != 1) write_reg(REG_HOP_LEN, shift_val);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
    end
    // the receiver goes quiet for a long stretch while samples keep coming
    if (hold) hold_req = 1'b1;
    pause_at = $urandom_range(0, n_items - 1);
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) drain_frames();
      it.sample = pick_sample(style);
      it.first  = (first_odds != 0) && ($urandom_range(1, first_odds) == 1);
      push_sample(it, 1'b0, none);
    end
  endtask

  // receiver: stall patterns in segments of random length, plus the long
  // hold-off when asked for, timed here in cycles
  initial begin : receiver
    stall_mode_e mode;
    int          seg;
    logic [15:0] mask;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        mode = stall_mode_e'($urandom_range(0, 3));
        seg  = $urandom_range(20, 150);
        mask = 16'($urandom);
        for (int i = 0; i < seg && !hold_req; i++) begin
          case (mode)
            STALL_NONE: out_stall <= 1'b0;
            STALL_MASK: out_stall <= mask[i % 16];
            STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
            default:    out_stall <= ($urandom_range(0, 7) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // result checker: every output transaction against the oldest frame due
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        n_err++;
        if (n_shown < 10) begin
          n_shown++;
          $display("unexpected frame: log %0d energy %0d",
                   out_data.log_energy, out_data.frame_energy);
        end
      end else begin
        due_frame = frames_due.pop_front();
        if (out_data.log_energy !== due_frame.log_energy ||
            out_data.frame_energy !== due_frame.frame_energy) begin
          n_err++;
          if (n_shown < 10) begin
            n_shown++;
            $display("frame mismatch: log exp %0d got %0d, energy exp %0d got %0d",
                     due_frame.log_energy, out_data.log_energy,
                     due_frame.frame_energy, out_data.frame_energy);
          end
        end
      end
    end
  end

  initial begin
    in_item_t  it;
    out_item_t want;
    row_t      row;
    int        len_v;
    int        shift_v;
    int        eff;
    int        r;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    n_err      = 0;
    n_shown    = 0;
    hold_req   = 1'b0;
    burst_left = 0;
    rand_sent  = 0;
    for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
    restart_window();
    // reset values of the two registers
    len_reg   = 11'd400;
    shift_reg = 11'd160;

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting untouched: one frame once 400 samples are in
    run_phase(1'b0, '0, '0, 405, 0, 0, 1'b0);

    // directed table
    for (int i = 0; i < N_ROWS; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.idx, row.arg[CFG_W-1:0]);
      end else begin
        it.sample         = row.arg;
        it.first          = row.first;
        want.log_energy   = row.log_e;
        want.frame_energy = row.energy;
        push_sample(it, row.typed, want);
      end
    end

    // short frames, a frame every sample, with the receiver holding off
    run_phase(1'b1, 11'd4, 11'd1, 60, 0, 0, 1'b1);
    // length above the ring size is cut to the ring size, full-scale data
    run_phase(1'b1, 11'd2047, 11'd0, 1030, 2, 0, 1'b0);

    // random settings, mostly small frames
    while (rand_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 5) len_v = 0;
      else if (r < 15) len_v = $urandom_range(65, 300);
      else len_v = $urandom_range(1, 64);
      eff = (len_v == 0) ? 1 : len_v;
      r = $urandom_range(0, 99);
      if (r < 10) shift_v = 0;
      else if (r < 20) shift_v = 2047;
      else shift_v = $urandom_range(1, eff + 3);
      eff = eff + $urandom_range(10, 60);
      run_phase($urandom_range(0, 7) != 0, CFG_W'(len_v), CFG_W'(shift_v), eff,
                $urandom_range(0, 4), 40, 1'b0);
      rand_sent += eff;
    end

    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (n_err == 0 && frames_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
